// File: src/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants of the serial command to I2C frame decoder.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam logic [7:0] PATTERN_OPCODE = 8'h21;
    localparam logic [7:0] BROADCAST_ADDR = 8'h00;
    localparam logic [7:0] REMOTE_RESET   = 8'h30;

    localparam logic [2:0] REG_WRITE_WORD = 3'd0;
    localparam logic [2:0] REG_INCLUDE    = 3'd1;
    localparam logic [2:0] REG_EXCLUDE    = 3'd2;
    localparam logic [2:0] REG_ISYNC      = 3'd3;
    localparam logic [2:0] REG_ESYNC      = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PATTERN,
        CMD_SET_REMOTE,
        CMD_INCLUDE,
        CMD_EXCLUDE,
        CMD_ISYNC,
        CMD_ESYNC,
        CMD_RED,
        CMD_GREEN,
        CMD_BLUE,
        CMD_ABORT
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       is_hex;
        logic [3:0] hex;
    } token_t;

    typedef struct packed {
        logic [7:0] write_word;
        logic [7:0] incl;
        logic [7:0] exclude;
        logic [7:0] isync;
        logic [7:0] esync;
    } opcodes_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_COLOUR,
        MODE_HEX
    } mode_t;

    typedef enum logic [2:0] {
        DST_REMOTE,
        DST_INC_TARGET,
        DST_INC_PHASE,
        DST_EXC_TARGET,
        DST_ISYNC_PHASE
    } dest_t;

endpackage

// File: src/scf_regs.sv
// ----------------------------------------------------------------------------
// scf_regs
// APB register file holding the five command opcodes.
// ----------------------------------------------------------------------------
module scf_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output scf_pkg::opcodes_t  opcodes
);
    import scf_pkg::*;

    opcodes_t   opc_reg;
    logic       wr_en;
    logic [2:0] index;
    logic [7:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign index   = paddr[4:2];
    assign opcodes = opc_reg;
    assign prdata  = {24'd0, rd_byte};

    always_comb
    begin
        unique case (index)
            REG_WRITE_WORD: rd_byte = opc_reg.write_word;
            REG_INCLUDE:    rd_byte = opc_reg.incl;
            REG_EXCLUDE:    rd_byte = opc_reg.exclude;
            REG_ISYNC:      rd_byte = opc_reg.isync;
            REG_ESYNC:      rd_byte = opc_reg.esync;
            default:        rd_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opc_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_WRITE_WORD: opc_reg.write_word <= pwdata[7:0];
                REG_INCLUDE:    opc_reg.incl       <= pwdata[7:0];
                REG_EXCLUDE:    opc_reg.exclude    <= pwdata[7:0];
                REG_ISYNC:      opc_reg.isync      <= pwdata[7:0];
                REG_ESYNC:      opc_reg.esync      <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

endmodule

// File: src/scf_front.sv
// ----------------------------------------------------------------------------
// scf_front
// Accepts received characters and classifies each into a command token.
// ----------------------------------------------------------------------------
module scf_front (
    input  logic            rx_valid,
    output logic            rx_stall,
    input  logic [7:0]      rx_byte,
    input  logic            queue_full,
    output logic            push,
    output scf_pkg::token_t token
);
    import scf_pkg::*;

    assign rx_stall = queue_full;
    assign push     = rx_valid & ~queue_full;

    always_comb
    begin
        token.is_hex = 1'b0;
        token.hex    = 4'd0;
        if (rx_byte >= "0" && rx_byte <= "9")
        begin
            token.is_hex = 1'b1;
            token.hex    = 4'(rx_byte - 8'h30);
        end
        else if (rx_byte >= "a" && rx_byte <= "f")
        begin
            token.is_hex = 1'b1;
            token.hex    = 4'(rx_byte - 8'h57);
        end
        else if (rx_byte >= "A" && rx_byte <= "F")
        begin
            token.is_hex = 1'b1;
            token.hex    = 4'(rx_byte - 8'h37);
        end
    end

    always_comb
    begin
        unique case (rx_byte)
            "0", "1", "2": token.cmd = CMD_PATTERN;
            "t":           token.cmd = CMD_SET_REMOTE;
            "i":           token.cmd = CMD_INCLUDE;
            "e":           token.cmd = CMD_EXCLUDE;
            "s":           token.cmd = CMD_ISYNC;
            "S":           token.cmd = CMD_ESYNC;
            "r":           token.cmd = CMD_RED;
            "g":           token.cmd = CMD_GREEN;
            "b":           token.cmd = CMD_BLUE;
            "x":           token.cmd = CMD_ABORT;
            default:       token.cmd = CMD_NONE;
        endcase
    end

endmodule

// File: src/scf_queue.sv
// ----------------------------------------------------------------------------
// scf_queue
// Two-entry token queue between the front and back parts.
// ----------------------------------------------------------------------------
module scf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scf_pkg::token_t push_token,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output scf_pkg::token_t pop_token
);
    import scf_pkg::*;

    token_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_token = mem[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: src/scf_back.sv
// ----------------------------------------------------------------------------
// scf_back
// Runs the command parser on tokens and registers the I2C frames it builds.
// ----------------------------------------------------------------------------
module scf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  scf_pkg::opcodes_t opcodes,
    input  logic              tok_valid,
    input  scf_pkg::token_t   token,
    output logic              pop,
    output logic              frame_valid,
    input  logic              frame_stall,
    output logic [7:0]        dest_address,
    output logic [2:0]        byte_count,
    output logic [7:0]        byte0,
    output logic [7:0]        byte1,
    output logic [7:0]        byte2,
    output logic [7:0]        byte3
);
    import scf_pkg::*;

    mode_t      mode_reg,    mode_next;
    dest_t      dst_reg,     dst_next;
    logic [1:0] digit_reg,   digit_next;
    logic [1:0] chan_reg,    chan_next;
    logic [7:0] high_reg,    high_next;
    logic [7:0] low_reg,     low_next;
    logic [7:0] asm_reg,     asm_next;
    logic [7:0] remote_reg,  remote_next;
    logic [7:0] target_reg,  target_next;
    logic [7:0] phase_reg,   phase_next;

    logic       valid_reg;
    logic [7:0] dest_reg;
    logic [2:0] count_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg, b3_reg;

    logic       fire;
    logic [7:0] f_dest;
    logic [2:0] f_count;
    logic [7:0] f_b0, f_b1, f_b2, f_b3;
    logic [7:0] hex_byte;

    assign pop          = tok_valid & (~valid_reg | ~frame_stall);
    assign hex_byte     = {asm_reg[7:4], token.hex};
    assign frame_valid  = valid_reg;
    assign dest_address = dest_reg;
    assign byte_count   = count_reg;
    assign byte0        = b0_reg;
    assign byte1        = b1_reg;
    assign byte2        = b2_reg;
    assign byte3        = b3_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        dst_next    = dst_reg;
        digit_next  = digit_reg;
        chan_next   = chan_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        asm_next    = asm_reg;
        remote_next = remote_reg;
        target_next = target_reg;
        phase_next  = phase_reg;
        unique case (mode_reg)
            MODE_COLOUR:
            begin
                if (token.cmd == CMD_ABORT)
                begin
                    mode_next = MODE_NORMAL;
                end
                else if (token.is_hex)
                begin
                    digit_next = digit_reg + 2'd1;
                    unique case (digit_reg)
                        2'd0: high_next = {token.hex, 4'd0};
                        2'd1: high_next = {high_reg[7:4], token.hex};
                        2'd2: low_next  = {token.hex, 4'd0};
                        default:
                        begin
                            low_next  = {low_reg[7:4], token.hex};
                            mode_next = MODE_NORMAL;
                        end
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (!token.is_hex)
                begin
                    mode_next = MODE_NORMAL;
                end
                else if (digit_reg == 2'd0)
                begin
                    asm_next   = {token.hex, 4'd0};
                    digit_next = 2'd1;
                end
                else
                begin
                    asm_next   = hex_byte;
                    digit_next = 2'd0;
                    mode_next  = MODE_NORMAL;
                    unique case (dst_reg)
                        DST_REMOTE:     remote_next = hex_byte;
                        DST_INC_TARGET:
                        begin
                            target_next = hex_byte;
                            mode_next   = MODE_HEX;
                            dst_next    = DST_INC_PHASE;
                        end
                        DST_INC_PHASE:   phase_next  = hex_byte;
                        DST_EXC_TARGET:  target_next = hex_byte;
                        DST_ISYNC_PHASE: phase_next  = hex_byte;
                        default:         ;
                    endcase
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                unique case (token.cmd)
                    CMD_PATTERN: asm_next = {4'd0, token.hex};
                    CMD_SET_REMOTE, CMD_INCLUDE, CMD_EXCLUDE, CMD_ISYNC:
                    begin
                        mode_next  = MODE_HEX;
                        digit_next = 2'd0;
                        unique case (token.cmd)
                            CMD_SET_REMOTE: dst_next = DST_REMOTE;
                            CMD_INCLUDE:    dst_next = DST_INC_TARGET;
                            CMD_EXCLUDE:    dst_next = DST_EXC_TARGET;
                            default:        dst_next = DST_ISYNC_PHASE;
                        endcase
                    end
                    CMD_RED, CMD_GREEN, CMD_BLUE:
                    begin
                        mode_next  = MODE_COLOUR;
                        high_next  = 8'd0;
                        low_next   = 8'd0;
                        digit_next = 2'd0;
                        unique case (token.cmd)
                            CMD_RED:   chan_next = 2'd0;
                            CMD_GREEN: chan_next = 2'd1;
                            default:   chan_next = 2'd2;
                        endcase
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_comb
    begin
        fire    = 1'b0;
        f_dest  = 8'd0;
        f_count = 3'd1;
        f_b0    = 8'd0;
        f_b1    = 8'd0;
        f_b2    = 8'd0;
        f_b3    = 8'd0;
        unique case (mode_reg)
            MODE_COLOUR:
            begin
                if (token.cmd != CMD_ABORT && token.is_hex && digit_reg == 2'd3)
                begin
                    fire    = 1'b1;
                    f_dest  = remote_reg;
                    f_count = 3'd4;
                    f_b0    = opcodes.write_word;
                    f_b1    = {6'd0, chan_reg};
                    f_b2    = {low_reg[7:4], token.hex};
                    f_b3    = high_reg;
                end
            end
            MODE_HEX:
            begin
                if (token.is_hex && digit_reg != 2'd0)
                begin
                    unique case (dst_reg)
                        DST_INC_PHASE:
                        begin
                            fire    = 1'b1;
                            f_dest  = target_reg;
                            f_count = 3'd2;
                            f_b0    = opcodes.incl;
                            f_b1    = hex_byte;
                        end
                        DST_EXC_TARGET:
                        begin
                            fire    = 1'b1;
                            f_dest  = hex_byte;
                            f_b0    = opcodes.exclude;
                        end
                        DST_ISYNC_PHASE:
                        begin
                            fire    = 1'b1;
                            f_dest  = BROADCAST_ADDR;
                            f_count = 3'd2;
                            f_b0    = opcodes.isync;
                            f_b1    = hex_byte;
                        end
                        default: ;
                    endcase
                end
            end
            default:
            begin
                if (token.cmd == CMD_PATTERN)
                begin
                    fire    = 1'b1;
                    f_dest  = remote_reg;
                    f_count = 3'd2;
                    f_b0    = PATTERN_OPCODE;
                    f_b1    = {4'd0, token.hex};
                end
                else if (token.cmd == CMD_ESYNC)
                begin
                    fire    = 1'b1;
                    f_dest  = BROADCAST_ADDR;
                    f_b0    = opcodes.esync;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            dst_reg    <= DST_REMOTE;
            digit_reg  <= 2'd0;
            chan_reg   <= 2'd0;
            high_reg   <= 8'd0;
            low_reg    <= 8'd0;
            asm_reg    <= 8'd0;
            remote_reg <= REMOTE_RESET;
            target_reg <= 8'd0;
            phase_reg  <= 8'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg   <= mode_next;
                dst_reg    <= dst_next;
                digit_reg  <= digit_next;
                chan_reg   <= chan_next;
                high_reg   <= high_next;
                low_reg    <= low_next;
                asm_reg    <= asm_next;
                remote_reg <= remote_next;
                target_reg <= target_next;
                phase_reg  <= phase_next;
            end
            if (pop && fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && fire)
        begin
            dest_reg  <= f_dest;
            count_reg <= f_count;
            b0_reg    <= f_b0;
            b1_reg    <= f_b1;
            b2_reg    <= f_b2;
            b3_reg    <= f_b3;
        end
    end

endmodule

// File: src/serial_command_to_i2c_frame.sv
// ----------------------------------------------------------------------------
// serial_command_to_i2c_frame
// Decodes one-letter serial commands into I2C write frames.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid/rx_stall    rx_byte
//   frame    out        frame_valid/stall    dest_address, byte_count, byte0..3
//   apb      in         psel/penable/pready  paddr, pwdata, prdata
//
// One character per cycle is accepted while the queue is not full; the parser
// consumes one token a cycle unless a valid frame is stalled. A frame rises
// once its last character has passed through the queue into the frame output
// register. Reset clears the parser state, the queue and the opcode registers.
// A stalled frame holds; the two-entry queue keeps taking characters until full.
// ----------------------------------------------------------------------------
module serial_command_to_i2c_frame (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [7:0]  dest_address,
    output logic [2:0]  byte_count,
    output logic [7:0]  byte0,
    output logic [7:0]  byte1,
    output logic [7:0]  byte2,
    output logic [7:0]  byte3
);
    import scf_pkg::*;

    opcodes_t opcodes;
    token_t   push_token;
    token_t   pop_token;
    logic     push;
    logic     queue_full;
    logic     pop;
    logic     pop_valid;

    scf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .opcodes (opcodes)
    );

    scf_front u_front (
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    scf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_token  (pop_token)
    );

    scf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcodes      (opcodes),
        .tok_valid    (pop_valid),
        .token        (pop_token),
        .pop          (pop),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .dest_address (dest_address),
        .byte_count   (byte_count),
        .byte0        (byte0),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3)
    );

endmodule
